FILE: src/ktose_pkg.sv
// ktose_pkg: shared constants for the keyed table with oldest-seen eviction
// no dependencies; imported by ktose_scan and keyed_table_oldest_seen_eviction_core
package ktose_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned KEY_BITS_DEF    = 64;
  localparam int unsigned TIME_BITS_DEF   = 32;

  // request and result field widths on the stream ports
  localparam int unsigned OP_W    = 3;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 5;

  localparam int unsigned IN_DATA_W  = KEY_W + 2 * TIME_W;
  localparam int unsigned OUT_BITS   = 1 + 2 * TIME_W + 1 + KEY_W + COUNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

  // input tdata offsets
  localparam int unsigned IN_KEY_LSB    = 0;
  localparam int unsigned IN_PAIRED_LSB = KEY_W;
  localparam int unsigned IN_SEEN_LSB   = KEY_W + TIME_W;

  // request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_REMEMBER = 3'd0,
    OP_LOOKUP   = 3'd1,
    OP_FORGET   = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_LOAD     = 3'd4
  } op_e;

endpackage

FILE: src/keyed_table_oldest_seen_eviction_core.sv
// keyed_table_oldest_seen_eviction_core: top level of the keyed table
// uses ktose_pkg and ktose_scan; the table lives in a local simple dual-port memory
//
// Requests come in on s_axis: tuser carries the operation (0 remember, 1 lookup,
// 2 forget, 3 clear, 4 load entry), tdata carries key, paired time and seen time.
// Every request gives exactly one result on m_axis.
// The table is a compacted list of entries held in a memory with one write and one
// registered read per cycle. A remember, lookup, forget or load request first scans
// all n valid entries through the shared compare unit, then may shift the entries
// behind a removed one down by one, then may append, then loads the result register.
// A clear, a zero key or an unused code goes straight to loading the result register.
// s_axis_tready is low from acceptance until the result register is loaded and rises
// as the result becomes valid, so a new request is accepted only after that.
// The result register holds one finished result; a new request is accepted while it
// waits, and the block only stalls at the end of that request if the receiver has
// still not taken the earlier result.
// Reset empties the table (the entry count goes to zero) and drops any pending
// result; memory contents are not cleared since only entries below the count are read.
module keyed_table_oldest_seen_eviction_core #(
  parameter int unsigned MAX_ENTRIES = ktose_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned KEY_BITS    = ktose_pkg::KEY_BITS_DEF,
  parameter int unsigned TIME_BITS   = ktose_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // key [63:0], paired_time [95:64], seen_time [127:96]
  input  logic [ktose_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // operation [2:0]
  input  logic [ktose_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // hit [0], stored_paired [32:1], stored_seen [64:33], evicted [65],
  // evicted_key [129:66], entry_count [134:130], zero [135]
  output logic [ktose_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import ktose_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned TW = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_APPEND,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TW-1:0]       paired;
    logic [TW-1:0]       seen;
  } entry_t;

  entry_t mem_q [MAX_ENTRIES];
  entry_t rd_data_q;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     wa;
  entry_t            wd;

  state_e              state_q;
  op_e                 op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [TW-1:0]       pt_q;
  logic [TW-1:0]       st_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       ptr_q;
  logic                pend_q;
  logic [AW-1:0]       pend_idx_q;
  logic                do_app_q;
  logic [TW-1:0]       app_p_q;
  logic                hit_q;
  logic                ev_q;
  logic [KEY_BITS-1:0] evk_q;
  logic [TW-1:0]       rp_q;
  logic [TW-1:0]       rs_q;
  logic                out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic [KEY_BITS-1:0] in_key;
  logic [TW-1:0]       in_pt;
  logic [TW-1:0]       in_st;
  logic                accept;
  logic                ptr_more;

  logic                found;
  logic [AW-1:0]       at_idx;
  logic [TW-1:0]       at_paired;
  logic [TW-1:0]       at_seen;
  logic [AW-1:0]       old_idx;
  logic [KEY_BITS-1:0] old_key;

  assign in_key   = s_axis_tdata[IN_KEY_LSB +: KEY_BITS];
  assign in_pt    = s_axis_tdata[IN_PAIRED_LSB +: TW];
  assign in_st    = s_axis_tdata[IN_SEEN_LSB +: TW];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign ptr_more = (ptr_q < count_q);

  ktose_scan #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (accept),
    .vld_i       ((state_q == ST_SCAN) && pend_q),
    .idx_i       (pend_idx_q),
    .want_key_i  (key_q),
    .key_i       (rd_data_q.key),
    .paired_i    (rd_data_q.paired),
    .seen_i      (rd_data_q.seen),
    .found_o     (found),
    .at_idx_o    (at_idx),
    .at_paired_o (at_paired),
    .at_seen_o   (at_seen),
    .old_idx_o   (old_idx),
    .old_key_o   (old_key)
  );

  // memory port control
  always_comb begin
    rd_en   = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && ptr_more;
    rd_addr = ptr_q[AW-1:0];
    we      = 1'b0;
    wa      = '0;
    wd      = rd_data_q;
    case (state_q)
      ST_DECIDE: begin
        if (op_q == OP_REMEMBER && found) begin
          we = 1'b1;
          wa = at_idx;
          wd = '{key: key_q, paired: at_paired, seen: st_q};
        end
      end
      ST_SHIFT: begin
        if (pend_q) begin
          we = 1'b1;
          wa = pend_idx_q - AW'(1);
          wd = rd_data_q;
        end
      end
      ST_APPEND: begin
        we = 1'b1;
        wa = count_q[AW-1:0];
        wd = '{key: key_q, paired: app_p_q, seen: st_q};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_REMEMBER;
      count_q     <= '0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      do_app_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (m_axis_tready && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q     <= op_e'(s_axis_tuser);
            key_q    <= in_key;
            pt_q     <= in_pt;
            st_q     <= in_st;
            hit_q    <= 1'b0;
            ev_q     <= 1'b0;
            evk_q    <= '0;
            rp_q     <= '0;
            rs_q     <= '0;
            do_app_q <= 1'b0;
            ptr_q    <= '0;
            pend_q   <= 1'b0;
            if (op_e'(s_axis_tuser) == OP_CLEAR) begin
              count_q <= '0;
              state_q <= ST_FINISH;
            end else if (in_key == '0 || s_axis_tuser > OP_W'(OP_LOAD)) begin
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          pend_q     <= ptr_more;
          pend_idx_q <= ptr_q[AW-1:0];
          if (ptr_more) begin
            ptr_q <= ptr_q + CW'(1);
          end else if (!pend_q) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          hit_q  <= found;
          pend_q <= 1'b0;
          case (op_q)
            OP_REMEMBER: begin
              rs_q    <= st_q;
              app_p_q <= st_q;
              if (found) begin
                rp_q    <= at_paired;
                state_q <= ST_FINISH;
              end else begin
                rp_q <= st_q;
                if (count_q < MaxCount) begin
                  state_q <= ST_APPEND;
                end else begin
                  ev_q     <= 1'b1;
                  evk_q    <= old_key;
                  ptr_q    <= CW'(old_idx) + CW'(1);
                  do_app_q <= 1'b1;
                  state_q  <= ST_SHIFT;
                end
              end
            end
            OP_LOOKUP: begin
              if (found) begin
                rp_q <= at_paired;
                rs_q <= at_seen;
              end
              state_q <= ST_FINISH;
            end
            OP_FORGET: begin
              if (found) begin
                ptr_q   <= CW'(at_idx) + CW'(1);
                state_q <= ST_SHIFT;
              end else begin
                state_q <= ST_FINISH;
              end
            end
            OP_LOAD: begin
              rp_q    <= pt_q;
              rs_q    <= st_q;
              app_p_q <= pt_q;
              if (found) begin
                ptr_q    <= CW'(at_idx) + CW'(1);
                do_app_q <= 1'b1;
                state_q  <= ST_SHIFT;
              end else if (count_q < MaxCount) begin
                state_q <= ST_APPEND;
              end else begin
                ev_q     <= 1'b1;
                evk_q    <= old_key;
                ptr_q    <= CW'(old_idx) + CW'(1);
                do_app_q <= 1'b1;
                state_q  <= ST_SHIFT;
              end
            end
            default: begin
              state_q <= ST_FINISH;
            end
          endcase
        end
        ST_SHIFT: begin
          pend_q     <= ptr_more;
          pend_idx_q <= ptr_q[AW-1:0];
          if (ptr_more) begin
            ptr_q <= ptr_q + CW'(1);
          end else if (!pend_q) begin
            count_q <= count_q - CW'(1);
            state_q <= do_app_q ? ST_APPEND : ST_FINISH;
          end
        end
        ST_APPEND: begin
          count_q <= count_q + CW'(1);
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {{OUT_PAD_W{1'b0}}, COUNT_W'(count_q), KEY_W'(evk_q), ev_q,
                            TIME_W'(rs_q), TIME_W'(rp_q), hit_q};
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: src/ktose_scan.sv
// ktose_scan: compare unit used once per table entry during a scan
// tracks the first key match and the oldest last-seen entry; uses ktose_pkg
module ktose_scan #(
  parameter int unsigned MAX_ENTRIES = ktose_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned KEY_BITS    = ktose_pkg::KEY_BITS_DEF,
  parameter int unsigned TIME_BITS   = ktose_pkg::TIME_BITS_DEF,
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned TW = (TIME_BITS < 32) ? TIME_BITS : 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clr_i,
  input  logic                vld_i,
  input  logic [AW-1:0]       idx_i,
  input  logic [KEY_BITS-1:0] want_key_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [TW-1:0]       paired_i,
  input  logic [TW-1:0]       seen_i,
  output logic                found_o,
  output logic [AW-1:0]       at_idx_o,
  output logic [TW-1:0]       at_paired_o,
  output logic [TW-1:0]       at_seen_o,
  output logic [AW-1:0]       old_idx_o,
  output logic [KEY_BITS-1:0] old_key_o
);
  import ktose_pkg::*;

  logic                found_q;
  logic [AW-1:0]       at_idx_q;
  logic [TW-1:0]       at_paired_q;
  logic [TW-1:0]       at_seen_q;
  logic [AW-1:0]       old_idx_q;
  logic [KEY_BITS-1:0] old_key_q;
  logic [TW-1:0]       old_seen_q;
  logic                key_eq;
  logic                older;

  assign key_eq = (key_i == want_key_i);
  // strict compare keeps the earliest entry on a tie
  assign older  = (idx_i == '0) || (seen_i < old_seen_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (clr_i) begin
      found_q <= 1'b0;
    end else if (vld_i && !found_q && key_eq) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i && !found_q && key_eq) begin
      at_idx_q    <= idx_i;
      at_paired_q <= paired_i;
      at_seen_q   <= seen_i;
    end
    if (vld_i && older) begin
      old_idx_q  <= idx_i;
      old_key_q  <= key_i;
      old_seen_q <= seen_i;
    end
  end

  assign found_o     = found_q;
  assign at_idx_o    = at_idx_q;
  assign at_paired_o = at_paired_q;
  assign at_seen_o   = at_seen_q;
  assign old_idx_o   = old_idx_q;
  assign old_key_o   = old_key_q;

endmodule
